[design/pfa_pkg.sv]
package pfa_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int CRD_W = 32;
  localparam int SUM_W = 48;
  localparam int R2_W = 64;
  localparam int NUM_W = 128;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [1:0] {
    CFG_CUTOFF = 2'd0,
    CFG_MINRAD = 2'd1,
    CFG_INVMASS = 2'd2
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIFF,
    ST_SQ,
    ST_R2,
    ST_SQRT,
    ST_DEN,
    ST_MASS,
    ST_NUM,
    ST_DIV_GO,
    ST_DIV,
    ST_ACC,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic diff;
    logic sq;
    logic r2;
    logic sqrt_start;
    logic den;
    logic mass;
    logic num;
    logic div_start;
    logic acc;
    logic out_load;
  } ctrl_t;

  typedef struct packed {
    logic in_range;
    logic active;
    logic sqrt_done;
    logic div_done;
  } stat_t;

endpackage

[design/pfa_if.sv]
interface pfa_in_if;
  logic valid;
  logic ready;
  logic [31:0] self_x;
  logic [31:0] self_y;
  logic [31:0] other_x;
  logic [31:0] other_y;
  logic clear_sums;
  modport source (output valid, self_x, self_y, other_x, other_y, clear_sums, input ready);
  modport sink (input valid, self_x, self_y, other_x, other_y, clear_sums, output ready);
endinterface

interface pfa_out_if;
  logic valid;
  logic ready;
  logic signed [47:0] accel_x;
  logic signed [47:0] accel_y;
  logic within_cutoff;
  modport source (output valid, accel_x, accel_y, within_cutoff, input ready);
  modport sink (input valid, accel_x, accel_y, within_cutoff, output ready);
endinterface

[design/pfa_ctrl.sv]
module pfa_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  pfa_pkg::stat_t  stat,
  output pfa_pkg::ctrl_t  ctrl
);
  import pfa_pkg::*;

  state_t state_r, state_nxt;
  logic   ov_r, ov_nxt;

  // The output register frees the sequencer: a result may wait while the next pair is worked.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_DIFF;
      ST_DIFF:   state_nxt = ST_SQ;
      ST_SQ:     state_nxt = ST_R2;
      ST_R2:     state_nxt = stat.active ? ST_SQRT : ST_ACC;
      ST_SQRT:   if (stat.sqrt_done) state_nxt = ST_DEN;
      ST_DEN:    state_nxt = ST_MASS;
      ST_MASS:   state_nxt = ST_NUM;
      ST_NUM:    state_nxt = ST_DIV_GO;
      ST_DIV_GO: state_nxt = ST_DIV;
      ST_DIV:    if (stat.div_done) state_nxt = ST_ACC;
      ST_ACC:    state_nxt = ST_OUT;
      ST_OUT:    if (!ov_r || out_ready) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl = '0;
    unique case (state_r)
      ST_IDLE: ctrl.load = in_valid;
      ST_DIFF: ctrl.diff = 1'b1;
      ST_SQ:   ctrl.sq = 1'b1;
      ST_R2:   begin
        ctrl.r2 = 1'b1;
        ctrl.sqrt_start = stat.active;
      end
      ST_DEN:    ctrl.den = 1'b1;
      ST_MASS:   ctrl.mass = 1'b1;
      ST_NUM:    ctrl.num = 1'b1;
      ST_DIV_GO: ctrl.div_start = 1'b1;
      ST_ACC:    ctrl.acc = 1'b1;
      ST_OUT:    ctrl.out_load = !ov_r || out_ready;
      default:   ctrl = '0;
    endcase
  end

  assign in_ready = (state_r == ST_IDLE);
  assign out_valid = ov_r;

  always_comb begin
    ov_nxt = ov_r;
    if (out_ready) ov_nxt = 1'b0;
    if (ctrl.out_load) ov_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r <= ov_nxt;
    end
  end

endmodule

[design/pfa_sqrt.sv]
module pfa_sqrt (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [pfa_pkg::R2_W-1:0]   val,
  output logic [pfa_pkg::R2_W/2-1:0] root,
  output logic                       done
);
  import pfa_pkg::*;

  localparam int HW = R2_W / 2;
  localparam int CW = $clog2(HW + 1);

  logic [R2_W-1:0] rem_r, rem_nxt;
  logic [HW-1:0]   q_r, q_nxt;
  logic [R2_W-1:0] v_r, v_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            busy_r, busy_nxt;
  logic [R2_W+1:0] trial;
  logic [R2_W+1:0] shifted;

  // Two bits of the radicand enter per cycle; one root bit results.
  always_comb begin
    shifted = {rem_r, v_r[R2_W-1 -: 2]};
    trial = shifted - {{(R2_W-HW){1'b0}}, q_r, 2'b01};
    rem_nxt = rem_r;
    q_nxt = q_r;
    v_nxt = v_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      rem_nxt = '0;
      q_nxt = '0;
      v_nxt = val;
      cnt_nxt = CW'(HW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      v_nxt = {v_r[R2_W-3:0], 2'b00};
      if (!trial[R2_W+1]) begin
        rem_nxt = trial[R2_W-1:0];
        q_nxt = {q_r[HW-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[R2_W-1:0];
        q_nxt = {q_r[HW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) busy_nxt = 1'b0;
    end
  end

  assign root = q_r;
  assign done = busy_r && (cnt_r == CW'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    q_r <= q_nxt;
    v_r <= v_nxt;
  end

endmodule

[design/pfa_div.sv]
module pfa_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [pfa_pkg::NUM_W-1:0] num_a,
  input  logic [pfa_pkg::NUM_W-1:0] num_b,
  input  logic [pfa_pkg::NUM_W-1:0] den,
  output logic [pfa_pkg::NUM_W-1:0] quo_a,
  output logic [pfa_pkg::NUM_W-1:0] quo_b,
  output logic                      done
);
  import pfa_pkg::*;

  localparam int CW = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] ra_r, rb_r, qa_r, qb_r, d_r;
  logic [NUM_W:0]   sa, sb;
  logic [CW-1:0]    cnt_r;
  logic             busy_r;

  // Both terms share the divisor, so two restoring dividers run side by side, one bit a cycle.
  // The quotient shares its register with the numerator bits, and the remainder sits above them in one shift word.
  logic [2*NUM_W-1:0] wa, wb;
  assign wa = {ra_r, qa_r};
  assign wb = {rb_r, qb_r};
  assign sa = {wa[2*NUM_W-1:NUM_W-1]} - {1'b0, d_r};
  assign sb = {wb[2*NUM_W-1:NUM_W-1]} - {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r <= CW'(NUM_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CW'(1)) busy_r <= 1'b0;
    end
    if (start) begin
      ra_r <= '0;
      rb_r <= '0;
      qa_r <= num_a;
      qb_r <= num_b;
      d_r <= den;
    end else if (busy_r) begin
      if (!sa[NUM_W]) {ra_r, qa_r} <= {sa[NUM_W-1:0], qa_r[NUM_W-2:0], 1'b1};
      else {ra_r, qa_r} <= {wa[2*NUM_W-2:0], 1'b0};
      if (!sb[NUM_W]) {rb_r, qb_r} <= {sb[NUM_W-1:0], qb_r[NUM_W-2:0], 1'b1};
      else {rb_r, qb_r} <= {wb[2*NUM_W-2:0], 1'b0};
    end
  end

  assign quo_a = qa_r;
  assign quo_b = qb_r;
  assign done = busy_r && (cnt_r == CW'(1));

endmodule

[design/pfa_dp.sv]
module pfa_dp #(
  parameter int FRAC_BITS = pfa_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  pfa_pkg::ctrl_t                   ctrl,
  output pfa_pkg::stat_t                   stat,
  input  logic                             cfg_we,
  input  logic [pfa_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [pfa_pkg::CRD_W-1:0]        cfg_data,
  input  logic [pfa_pkg::CRD_W-1:0]        self_x,
  input  logic [pfa_pkg::CRD_W-1:0]        self_y,
  input  logic [pfa_pkg::CRD_W-1:0]        other_x,
  input  logic [pfa_pkg::CRD_W-1:0]        other_y,
  input  logic                             clear_sums,
  output logic signed [pfa_pkg::SUM_W-1:0] accel_x,
  output logic signed [pfa_pkg::SUM_W-1:0] accel_y,
  output logic                             within_cutoff
);
  import pfa_pkg::*;

  localparam logic [SUM_W:0] TERM_LIM = (SUM_W+1)'(1) << SUM_W;
  localparam logic signed [SUM_W+1:0] SMAX = (SUM_W+2)'((64'd1 << (SUM_W-1)) - 1);
  localparam logic signed [SUM_W+1:0] SMIN = -(SUM_W+2)'(64'd1 << (SUM_W-1));

  logic [CRD_W-1:0] cut_r, minr_r, im_r;
  logic [CRD_W-1:0] sx_r, sy_r, ox_r, oy_r;
  logic             clr_r;
  logic [CRD_W-1:0] ux_r, uy_r;
  logic             nx_r, ny_r;
  logic [R2_W-1:0]  sqx_r, sqy_r, cut2_r, min2_r, r2c_r;
  logic             within_r, active_r;
  logic [R2_W:0]    r2sum;
  logic [R2_W-1:0]  r2v;
  logic [R2_W/2-1:0] root;
  logic             sqrt_done, div_done;
  logic [NUM_W-1:0] den_r, pa_r, pb_r, qa, qb;
  logic [CRD_W:0]   rc_r;
  logic             nrc_r;
  logic signed [SUM_W-1:0] ax_r, ay_r;
  logic signed [SUM_W-1:0] oax_r, oay_r;
  logic             ow_r;
  logic [SUM_W:0]   ma, mb;
  logic signed [SUM_W+1:0] ta, tb, na, nb;
  logic [CRD_W+CRD_W:0] rcm_r;
  logic [R2_W-1:0]  dlo, dhi, pxl, pyl;
  logic [R2_W:0]    pxh, pyh;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cut_r <= CRD_W'(655);
      minr_r <= CRD_W'(7);
      im_r <= CRD_W'(6553600);
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_CUTOFF:  cut_r <= cfg_data;
        CFG_MINRAD:  minr_r <= cfg_data;
        CFG_INVMASS: im_r <= cfg_data;
        default:     ;
      endcase
    end
  end

  assign r2sum = {1'b0, sqx_r} + {1'b0, sqy_r};
  assign r2v = r2sum[R2_W-1:0];

  // Wide products are split at bit 32 into a low and a high part and recombined by shift and add.
  assign dlo = root * r2c_r[R2_W/2-1:0];
  assign dhi = root * r2c_r[R2_W-1:R2_W/2];
  assign pxl = rcm_r[CRD_W-1:0] * ux_r;
  assign pyl = rcm_r[CRD_W-1:0] * uy_r;
  assign pxh = rcm_r[2*CRD_W:CRD_W] * ux_r;
  assign pyh = rcm_r[2*CRD_W:CRD_W] * uy_r;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      sx_r <= self_x;
      sy_r <= self_y;
      ox_r <= other_x;
      oy_r <= other_y;
      clr_r <= clear_sums;
    end
    if (ctrl.diff) begin
      nx_r <= ox_r < sx_r;
      ny_r <= oy_r < sy_r;
      ux_r <= (ox_r < sx_r) ? sx_r - ox_r : ox_r - sx_r;
      uy_r <= (oy_r < sy_r) ? sy_r - oy_r : oy_r - sy_r;
    end
    if (ctrl.sq) begin
      sqx_r <= ux_r * ux_r;
      sqy_r <= uy_r * uy_r;
      cut2_r <= cut_r * cut_r;
      min2_r <= minr_r * minr_r;
    end
    if (ctrl.r2) begin
      within_r <= !r2sum[R2_W] && (r2v <= cut2_r);
      active_r <= !r2sum[R2_W] && (r2v <= cut2_r) && ((r2v > min2_r) ? r2v : min2_r) != '0;
      r2c_r <= (r2v > min2_r) ? r2v : min2_r;
    end
    if (ctrl.den) begin
      den_r <= {{(NUM_W-R2_W-R2_W/2){1'b0}}, dhi, {(R2_W/2){1'b0}}}
             + {{(NUM_W-R2_W){1'b0}}, dlo};
      nrc_r <= root < cut_r;
      rc_r <= (root < cut_r) ? (CRD_W+1)'(cut_r - root) : (CRD_W+1)'(root - cut_r);
    end
    if (ctrl.mass) rcm_r <= rc_r * im_r;
    if (ctrl.num) begin
      pa_r <= NUM_W'({pxh, {CRD_W{1'b0}}} + {{(CRD_W+1){1'b0}}, pxl}) << FRAC_BITS;
      pb_r <= NUM_W'({pyh, {CRD_W{1'b0}}} + {{(CRD_W+1){1'b0}}, pyl}) << FRAC_BITS;
    end
  end

  pfa_sqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .start(ctrl.sqrt_start),
    .val((r2v > min2_r) ? r2v : min2_r), .root(root), .done(sqrt_done)
  );

  pfa_div u_div (
    .clk(clk), .rst_n(rst_n), .start(ctrl.div_start),
    .num_a(pa_r), .num_b(pb_r),
    .den(den_r), .quo_a(qa), .quo_b(qb), .done(div_done)
  );

  assign ma = (qa > NUM_W'(TERM_LIM)) ? TERM_LIM : qa[SUM_W:0];
  assign mb = (qb > NUM_W'(TERM_LIM)) ? TERM_LIM : qb[SUM_W:0];
  assign ta = (nrc_r != nx_r) ? -$signed({1'b0, ma}) : $signed({1'b0, ma});
  assign tb = (nrc_r != ny_r) ? -$signed({1'b0, mb}) : $signed({1'b0, mb});

  always_comb begin
    na = (clr_r ? '0 : (SUM_W+2)'(ax_r)) + (active_r ? ta : '0);
    nb = (clr_r ? '0 : (SUM_W+2)'(ay_r)) + (active_r ? tb : '0);
    if (na > SMAX) na = SMAX;
    if (na < SMIN) na = SMIN;
    if (nb > SMAX) nb = SMAX;
    if (nb < SMIN) nb = SMIN;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ax_r <= '0;
      ay_r <= '0;
    end else if (ctrl.acc) begin
      ax_r <= na[SUM_W-1:0];
      ay_r <= nb[SUM_W-1:0];
    end
    if (ctrl.out_load) begin
      oax_r <= ax_r;
      oay_r <= ay_r;
      ow_r <= within_r;
    end
  end

  assign stat.in_range = within_r;
  assign stat.active = !r2sum[R2_W] && (r2v <= cut2_r) && ((r2v > min2_r) ? r2v : min2_r) != '0;
  assign stat.sqrt_done = sqrt_done;
  assign stat.div_done = div_done;
  assign accel_x = oax_r;
  assign accel_y = oay_r;
  assign within_cutoff = ow_r;

endmodule

[design/pair_force_accumulate.sv]
// Pair force accumulator.
// The input channel carries one particle and one neighbour position per
// transaction, with a flag that clears both acceleration sums first. Each
// transaction yields exactly one result transaction: the x and y sums after
// that pair and whether it lay within the cutoff.
// Pairs are worked one at a time. A pair beyond the cutoff passes from
// acceptance through the difference, square and radius-squared states
// straight to accumulation and the output register; one that interacts
// first runs the 32-step square root and the 128-step divider pair. The
// next pair is accepted only after the output register has been loaded.
// The output register holds a finished result while the next pair is taken
// and worked, so a stalled receiver holds the next pair only at its output load.
// Configuration writes (cutoff, minimum radius, inverse mass) take effect at
// once and are meant only while the block is idle.
// Synchronous reset restores the default registers, zeroes the sums and
// empties the output register.
module pair_force_accumulate #(
  parameter int FRAC_BITS = pfa_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  pfa_in_if.sink                        in_ch,
  pfa_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [pfa_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [pfa_pkg::CRD_W-1:0]     cfg_data
);
  import pfa_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  pfa_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .stat(stat), .ctrl(ctrl)
  );

  pfa_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .ctrl(ctrl), .stat(stat),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .self_x(in_ch.self_x), .self_y(in_ch.self_y), .other_x(in_ch.other_x),
    .other_y(in_ch.other_y), .clear_sums(in_ch.clear_sums),
    .accel_x(out_ch.accel_x), .accel_y(out_ch.accel_y),
    .within_cutoff(out_ch.within_cutoff)
  );

  a_one_hot_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({ctrl.load, ctrl.sqrt_start, ctrl.num, ctrl.acc, ctrl.out_load}))
    else $error("more than one sequencer command at once");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.acc |-> !in_ch.ready)
    else $error("input ready while a pair is in work");
  a_out_follows_load: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.out_load |=> out_ch.valid)
    else $error("result not shown after loading the output register");

endmodule
